### hdl/pfdc_pkg.sv
// ----------------------------------------------------------------------------
// pfdc_pkg: shared types and constants of the clamped PID core
// Field widths, configuration register codes and the settings bundle.
// ----------------------------------------------------------------------------
package pfdc_pkg;

	localparam int SAMPLE_W = 16;                    // measurement, target, drive
	localparam int COEF_W   = 32;                    // Q16.16 coefficients
	localparam int ERR_W    = SAMPLE_W + 1;          // error never overflows
	localparam int FRAC_W   = 16;                    // fraction bits of the coefficients
	localparam int ERR_P_W  = COEF_W + ERR_W;        // error product width
	localparam int DRV_P_W  = COEF_W + SAMPLE_W;     // drive product width
	localparam int ACC_W    = ERR_P_W + 3;           // five terms summed exactly
	localparam int Y_W      = ACC_W - FRAC_W;        // after the truncating shift
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = COEF_W;

	localparam logic signed [SAMPLE_W-1:0] UPPER_RST = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] LOWER_RST = 16'sh8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_B0     = 3'd0,
		REG_COEF_B1     = 3'd1,
		REG_COEF_B2     = 3'd2,
		REG_COEF_A1     = 3'd3,
		REG_COEF_A2     = 3'd4,
		REG_UPPER_LIMIT = 3'd5,
		REG_LOWER_LIMIT = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COEF_W-1:0]   b0;
		logic signed [COEF_W-1:0]   b1;
		logic signed [COEF_W-1:0]   b2;
		logic signed [COEF_W-1:0]   a1;
		logic signed [COEF_W-1:0]   a2;
		logic signed [SAMPLE_W-1:0] upper;
		logic signed [SAMPLE_W-1:0] lower;
	} ctrl_cfg_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]    err_prev;
		logic signed [ERR_W-1:0]    err_prev2;
		logic signed [SAMPLE_W-1:0] drive_prev;
		logic signed [SAMPLE_W-1:0] drive_prev2;
	} ctrl_hist_t;

endpackage

### hdl/pfdc_law.sv
// ----------------------------------------------------------------------------
// pfdc_law: control law of the clamped PID core
// Five products, exact sum, truncating shift and upper-first clamp.
// ----------------------------------------------------------------------------
module pfdc_law import pfdc_pkg::*; (
	input  ctrl_cfg_t                  cfg,
	input  ctrl_hist_t                 hist,
	input  logic signed [ERR_W-1:0]    err,
	output logic signed [SAMPLE_W-1:0] drive
);

	logic signed [ERR_P_W-1:0] p_b0, p_b1, p_b2;
	logic signed [DRV_P_W-1:0] p_a1, p_a2;
	logic signed [ACC_W-1:0]   acc;
	logic signed [Y_W-1:0]     y_full;
	logic signed [Y_W-1:0]     upper_ext, lower_ext;

	assign p_b0 = cfg.b0 * err;
	assign p_b1 = cfg.b1 * hist.err_prev;
	assign p_b2 = cfg.b2 * hist.err_prev2;
	assign p_a1 = cfg.a1 * hist.drive_prev;
	assign p_a2 = cfg.a2 * hist.drive_prev2;

	assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
	           - ACC_W'(p_a1) - ACC_W'(p_a2);

	// drop the fraction: floor toward minus infinity
	assign y_full = acc[ACC_W-1:FRAC_W];

	assign upper_ext = Y_W'(cfg.upper);
	assign lower_ext = Y_W'(cfg.lower);

	always_comb begin
		priority if (y_full > upper_ext) begin
			drive = cfg.upper;
		end else if (y_full < lower_ext) begin
			drive = cfg.lower;
		end else begin
			drive = y_full[SAMPLE_W-1:0];
		end
	end

endmodule

### hdl/pid_filtered_derivative_clamped_core.sv
// ----------------------------------------------------------------------------
// pid_filtered_derivative_clamped_core: PID with filtered derivative and clamp
// Second-order difference equation on the error, clamped 16-bit drive output.
// ----------------------------------------------------------------------------
// Flow: a request's error is registered in stage 1; its drive is registered
// in the result register when stage 1 advances and shown on m_tdata.
// Throughput: one request per cycle unless m_tready stalls; drive history
// feeds straight back through one multiply-add-clamp path into the next sample.
// Reset: arst_n clears the histories and pipeline valids, sets coefficients
// to zero and the limits to the full 16-bit range.
module pid_filtered_derivative_clamped_core import pfdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // [15:0] measurement, [31:16] target
	// drive stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata    // [15:0] drive
);

	ctrl_cfg_t                  cfg_q;
	ctrl_hist_t                 hist_q;
	logic                       valid_s1;
	logic signed [ERR_W-1:0]    err_s1;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] drive_q;
	logic signed [SAMPLE_W-1:0] drive_d;
	logic signed [ERR_W-1:0]    err_in;
	logic                       advance;
	logic                       accept;

	// Configuration registers; unknown indexes drop the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.b0    <= '0;
			cfg_q.b1    <= '0;
			cfg_q.b2    <= '0;
			cfg_q.a1    <= '0;
			cfg_q.a2    <= '0;
			cfg_q.upper <= UPPER_RST;
			cfg_q.lower <= LOWER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEF_B0:     cfg_q.b0    <= cfg_data;
				REG_COEF_B1:     cfg_q.b1    <= cfg_data;
				REG_COEF_B2:     cfg_q.b2    <= cfg_data;
				REG_COEF_A1:     cfg_q.a1    <= cfg_data;
				REG_COEF_A2:     cfg_q.a2    <= cfg_data;
				REG_UPPER_LIMIT: cfg_q.upper <= cfg_data[SAMPLE_W-1:0];
				REG_LOWER_LIMIT: cfg_q.lower <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 advances whenever the result register is free or being emptied,
	// so a drive that is taken in this cycle does not stop new requests.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	// Form the 17-bit error on the way into stage 1.
	assign err_in = ERR_W'($signed(s_tdata[31:16])) - ERR_W'($signed(s_tdata[15:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1 <= err_in;
		end
	end

	pfdc_law u_law (
		.cfg   (cfg_q),
		.hist  (hist_q),
		.err   (err_s1),
		.drive (drive_d)
	);

	// Shift the histories only when the sample leaves stage 1, so the next
	// sample sees this drive in the very next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (advance) begin
			hist_q.err_prev2   <= hist_q.err_prev;
			hist_q.err_prev    <= err_s1;
			hist_q.drive_prev2 <= hist_q.drive_prev;
			hist_q.drive_prev  <= drive_d;
		end
	end

	// Result register: hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= drive_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = drive_q;

endmodule
